// ===== rtl/ecu_pkg.sv =====
// easing curve unit package: widths, fixed-point constants, command codes
// and the control word that travels alongside the curve pipelines
// no dependencies
`default_nettype none
package ecu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TW = FRAC_BITS + 1;
  localparam int XW = FRAC_BITS + 2;
  localparam int YW = FRAC_BITS + 1;
  localparam int CW = 3;

  // latency of every curve unit, set by the square root
  localparam int UNIT_LAT = FRAC_BITS + 4;
  localparam int BOUNCE_LAT = 3;
  localparam int QUINT_LAT = 5;

  localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

  typedef enum logic [CW-1:0] {
    CMD_UP_BOUNCE   = 3'd0,
    CMD_DOWN_BOUNCE = 3'd1,
    CMD_UP_CIRC     = 3'd2,
    CMD_DOWN_CIRC   = 3'd3,
    CMD_UP_QUINT    = 3'd4,
    CMD_DOWN_QUINT  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BOUNCE = 2'd0,
    KIND_CIRC   = 2'd1,
    KIND_QUINT  = 2'd2
  } kind_e;

  typedef struct packed {
    logic            pass;
    logic            down;
    kind_e           kind;
    logic [TW-1:0]   forced;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ecu_if.sv =====
// easing curve unit channels: progress input and eased result output
// depends on ecu_pkg
`default_nettype none
interface ecu_in_if
  import ecu_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CW-1:0]   cmd;
  logic [XW-1:0]   x;
  modport source (output valid, output cmd, output x, input ready);
  modport sink (input valid, input cmd, input x, output ready);
endinterface

interface ecu_out_if
  import ecu_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [YW-1:0]   y;
  modport source (output valid, output y, input ready);
  modport sink (input valid, input y, output ready);
endinterface
`default_nettype wire

// ===== rtl/easing_curve_unit.sv =====
// easing curve unit top level: decode stage, three curve pipelines, output stage
// depends on ecu_pkg, ecu_if, ecu_bounce, ecu_circ, ecu_quint
`default_nettype none
// Takes one progress value per cycle while the output is not stalled and returns
// one eased value per item, in order, through one decode stage, the curve units
// and one output register. The latency is set by the square root of the circ
// curve, which resolves one result bit per stage; bounce and quint are padded
// to match. All stages move together, so a stalled output holds the whole
// pipeline while the input stays ready whenever the output register is empty
// or being read.
module easing_curve_unit
  import ecu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ecu_in_if.sink     in_i,
  ecu_out_if.source  out_o
);
  logic          adv;
  logic          s0_vld_q;
  ctl_t          s0_ctl_q, s0_ctl_d;
  logic [TW-1:0] s0_t_q, s0_t_d;
  logic          vld_q [UNIT_LAT];
  ctl_t          ctl_q [UNIT_LAT];
  logic [TW-1:0] f_bounce, f_circ, f_quint, f_sel;
  logic          out_vld_q;
  logic [YW-1:0] y_q, y_d;
  ctl_t          ctl_last;
  localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
  localparam logic [XW-1:0] TWO_X = XW'(2) << FRAC_BITS;

  assign adv = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    s0_ctl_d.pass = 1'b0;
    s0_ctl_d.down = in_i.cmd[0];
    s0_ctl_d.forced = '0;
    s0_t_d = '0;
    case (in_i.cmd[CW-1:1])
      2'd0: s0_ctl_d.kind = KIND_BOUNCE;
      2'd1: s0_ctl_d.kind = KIND_CIRC;
      default: s0_ctl_d.kind = KIND_QUINT;
    endcase
    if (in_i.cmd <= CMD_DOWN_QUINT) begin
      if (!in_i.cmd[0]) begin
        if (in_i.x <= ONE_X) begin
          s0_ctl_d.pass = 1'b1;
          s0_t_d = in_i.x[TW-1:0];
        end else begin
          s0_ctl_d.forced = ONE_T;
        end
      end else if (in_i.x >= ONE_X) begin
        s0_ctl_d.pass = 1'b1;
        s0_t_d = (in_i.x >= TWO_X) ? '0 : TW'(TWO_X - in_i.x);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      for (int k = 0; k < UNIT_LAT; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_i.valid;
      vld_q[0] <= s0_vld_q;
      for (int k = 1; k < UNIT_LAT; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_ctl_q <= s0_ctl_d;
      s0_t_q <= s0_t_d;
      ctl_q[0] <= s0_ctl_q;
      for (int k = 1; k < UNIT_LAT; k++) ctl_q[k] <= ctl_q[k-1];
      y_q <= y_d;
    end
  end

  ecu_bounce u_bounce (.clk_i, .en_i(adv), .t_i(s0_t_q), .f_o(f_bounce));
  ecu_circ   u_circ   (.clk_i, .en_i(adv), .t_i(s0_t_q), .f_o(f_circ));
  ecu_quint  u_quint  (.clk_i, .en_i(adv), .t_i(s0_t_q), .f_o(f_quint));

  assign ctl_last = ctl_q[UNIT_LAT-1];

  always_comb begin
    case (ctl_last.kind)
      KIND_BOUNCE: f_sel = f_bounce;
      KIND_CIRC: f_sel = f_circ;
      default: f_sel = f_quint;
    endcase
    if (!ctl_last.pass) y_d = YW'(ctl_last.forced);
    else if (ctl_last.down) y_d = YW'(ONE_T - f_sel);
    else y_d = YW'(f_sel);
  end

  assign out_o.valid = out_vld_q;
  assign out_o.y = y_q;

`ifndef SYNTHESIS
  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.y <= YW'(ONE_T))
    else $error("result above one");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s0_vld_q) && $stable(vld_q[UNIT_LAT-1]))
    else $error("pipeline moved during stall");
  a_forced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_vld_q && !s0_ctl_q.pass && s0_ctl_q.down |-> s0_ctl_q.forced == '0)
    else $error("down direction below one not zero");
  a_pass_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_vld_q && s0_ctl_q.pass |-> s0_t_q <= ONE_T)
    else $error("curve argument above one");
`endif
endmodule
`default_nettype wire

// ===== rtl/ecu_bounce.sv =====
// out-bounce curve: segment pick, squared offset, add and clamp
// three stages padded to the common unit latency; depends on ecu_pkg
`default_nettype none
module ecu_bounce
  import ecu_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [TW-1:0] t_i,
  output logic [TW-1:0]      f_o
);
  localparam int EW = TW + 4;
  localparam int PAD = UNIT_LAT - BOUNCE_LAT + 1;
  localparam logic [EW-1:0] K4 = EW'(4) << FRAC_BITS;
  localparam logic [EW-1:0] K6 = EW'(6) << FRAC_BITS;
  localparam logic [EW-1:0] K8 = EW'(8) << FRAC_BITS;
  localparam logic [EW-1:0] K9 = EW'(9) << FRAC_BITS;
  localparam logic [EW-1:0] K10 = EW'(10) << FRAC_BITS;
  localparam logic [EW-1:0] K105 = EW'(21) << (FRAC_BITS - 1);
  localparam logic [TW:0] OFF1 = (TW+1)'(3) << (FRAC_BITS - 2);
  localparam logic [TW:0] OFF2 = (TW+1)'(15) << (FRAC_BITS - 4);
  localparam logic [TW:0] OFF3 = (TW+1)'(63) << (FRAC_BITS - 6);

  logic [EW-1:0]   t11;
  logic [EW-1:0]   e_d, e_q;
  logic [TW:0]     off_d, off_q, off2_q;
  logic [2*EW-1:0] e2_q;
  logic [2*EW-1:0] sq_w;
  logic [TW:0]     r_w;
  logic [TW-1:0]   y_d;
  logic [TW-1:0]   pad_q [PAD];

  assign t11 = EW'(t_i) * EW'(11);

  always_comb begin
    if (t11 < K4) begin
      e_d = t11;
      off_d = '0;
    end else if (t11 < K8) begin
      e_d = (t11 >= K6) ? t11 - K6 : K6 - t11;
      off_d = OFF1;
    end else if (t11 < K10) begin
      e_d = (t11 >= K9) ? t11 - K9 : K9 - t11;
      off_d = OFF2;
    end else begin
      e_d = (t11 >= K105) ? t11 - K105 : K105 - t11;
      off_d = OFF3;
    end
  end

  assign sq_w = ((e2_q >> (FRAC_BITS + 3)) + (2*EW)'(1)) >> 1;
  assign r_w = sq_w[TW:0] + off2_q;
  assign y_d = (r_w > (TW+1)'(ONE_T)) ? ONE_T : r_w[TW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
      off_q <= off_d;
      e2_q <= (2*EW)'(e_q) * (2*EW)'(e_q);
      off2_q <= off_q;
      pad_q[0] <= y_d;
      for (int k = 1; k < PAD; k++) pad_q[k] <= pad_q[k-1];
    end
  end

  assign f_o = pad_q[PAD-1];
endmodule
`default_nettype wire

// ===== rtl/ecu_quint.sv =====
// out-quint curve: four rounded multiplies of 1-t, then 1-p
// five stages padded to the common unit latency; depends on ecu_pkg
`default_nettype none
module ecu_quint
  import ecu_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [TW-1:0] t_i,
  output logic [TW-1:0]      f_o
);
  localparam int PW = 2 * TW;
  localparam int PAD = UNIT_LAT - QUINT_LAT + 1;

  logic [TW-1:0] u_q   [4];
  logic [PW-1:0] prod_q [4];
  logic [PW-1:0] rnd   [4];
  logic [TW-1:0] p_w;
  logic [TW-1:0] pad_q [PAD];

  for (genvar i = 0; i < 4; i++) begin : g_rnd
    assign rnd[i] = ((prod_q[i] >> (FRAC_BITS - 1)) + PW'(1)) >> 1;
  end
  assign p_w = (rnd[3] > PW'(ONE_T)) ? ONE_T : rnd[3][TW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q[0] <= ONE_T - t_i;
      prod_q[0] <= PW'(ONE_T - t_i) * PW'(ONE_T - t_i);
      for (int i = 1; i < 4; i++) begin
        u_q[i] <= u_q[i-1];
        prod_q[i] <= PW'(rnd[i-1][TW-1:0]) * PW'(u_q[i-1]);
      end
      pad_q[0] <= ONE_T - p_w;
      for (int k = 1; k < PAD; k++) pad_q[k] <= pad_q[k-1];
    end
  end

  assign f_o = pad_q[PAD-1];
endmodule
`default_nettype wire

// ===== rtl/ecu_circ.sv =====
// out-circ curve: sqrt(1-(1-t)^2), one result bit per stage, rounded
// to nearest; depends on ecu_pkg
`default_nettype none
module ecu_circ
  import ecu_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [TW-1:0] t_i,
  output logic [TW-1:0]      f_o
);
  localparam int VW = 2 * FRAC_BITS + 1;
  localparam int AW = VW + 2;
  localparam int NS = FRAC_BITS + 1;

  logic [2*TW-1:0] usq_q;
  logic [VW-1:0]   rem_q [NS+1];
  logic [TW-1:0]   res_q [NS+1];
  logic [TW-1:0]   fl_w;
  logic [TW:0]     y_w;
  logic [TW-1:0]   y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      usq_q <= (2*TW)'(ONE_T - t_i) * (2*TW)'(ONE_T - t_i);
      rem_q[0] <= VW'(((2*TW)'(1) << (2*FRAC_BITS)) - usq_q);
      res_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int B = FRAC_BITS - j;
    logic [AW-1:0] trial;
    logic          take;
    assign trial = (AW'(res_q[j]) << (B + 1)) + (AW'(1) << (2 * B));
    assign take = AW'(rem_q[j]) >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= take ? VW'(AW'(rem_q[j]) - trial) : rem_q[j];
        res_q[j+1] <= take ? (res_q[j] | (TW'(1) << B)) : res_q[j];
      end
    end
  end

  assign fl_w = res_q[NS];
  assign y_w = (rem_q[NS] > VW'(fl_w)) ? (TW+1)'(fl_w) + (TW+1)'(1) : (TW+1)'(fl_w);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= (y_w > (TW+1)'(ONE_T)) ? ONE_T : y_w[TW-1:0];
    end
  end

  assign f_o = y_q;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for easing_curve_unit: directed and random progress values per curve
// predicts eased values in fixed point and checks every result in order
// depends on ecu_pkg, ecu_if and the easing_curve_unit rtl
`default_nettype none
module tb;
  import ecu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ecu_in_if in_if ();
  ecu_out_if out_if ();

  easing_curve_unit dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source));

  logic [YW-1:0] eased_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_en = 1'b0;
  int hold_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] round_shift(logic [63:0] v, int s);
    return ((v >> (s - 1)) + 64'd1) >> 1;
  endfunction

  function automatic logic [63:0] bounce(logic [63:0] t);
    logic [63:0] t11, e, off, c, r;
    t11 = 64'd11 * t;
    if (t11 < 4 * ONE) begin
      e = t11;
      off = 0;
    end else if (t11 < 8 * ONE) begin
      c = 6 * ONE;
      e = (t11 >= c) ? t11 - c : c - t11;
      off = (3 * ONE) >> 2;
    end else if (t11 < 10 * ONE) begin
      c = 9 * ONE;
      e = (t11 >= c) ? t11 - c : c - t11;
      off = (15 * ONE) >> 4;
    end else begin
      c = (21 * ONE) >> 1;
      e = (t11 >= c) ? t11 - c : c - t11;
      off = (63 * ONE) >> 6;
    end
    r = round_shift(e * e, FRAC_BITS + 4) + off;
    return (r > ONE) ? ONE : r;
  endfunction

  function automatic logic [63:0] circ(logic [63:0] t);
    logic [63:0] u, v, lo, hi, mid;
    u = ONE - t;
    v = ONE * ONE - u * u;
    lo = 0;
    hi = ONE + 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    if (v - lo * lo > lo) lo = lo + 1;
    return (lo > ONE) ? ONE : lo;
  endfunction

  function automatic logic [63:0] quint(logic [63:0] t);
    logic [63:0] u, p;
    u = ONE - t;
    p = u;
    for (int i = 0; i < 4; i++) p = round_shift(p * u, FRAC_BITS);
    if (p > ONE) p = ONE;
    return ONE - p;
  endfunction

  function automatic logic [63:0] curve(kind_e k, logic [63:0] t);
    case (k)
      KIND_BOUNCE: return bounce(t);
      KIND_CIRC: return circ(t);
      default: return quint(t);
    endcase
  endfunction

  function automatic logic [YW-1:0] eased_value(logic [CW-1:0] cmd, logic [XW-1:0] x);
    logic [63:0] xv, t, y;
    kind_e k;
    xv = x;
    y = 0;
    k = kind_e'(cmd >> 1);
    if (cmd <= CMD_DOWN_QUINT) begin
      if (!cmd[0]) y = (xv <= ONE) ? curve(k, xv) : ONE;
      else if (xv >= ONE) begin
        t = (xv >= 2 * ONE) ? 0 : 2 * ONE - xv;
        y = ONE - curve(k, t);
      end
    end
    return y[YW-1:0];
  endfunction

  task automatic send(logic [CW-1:0] cmd, logic [XW-1:0] x);
    while (idle_en && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.x <= x;
    eased_q.push_back(eased_value(cmd, x));
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [XW-1:0] rand_x();
    case ($urandom_range(9))
      0: return XW'($urandom);
      1: return XW'(ONE + $urandom_range(2) - 1);
      2: return XW'($urandom_range(4));
      3: return XW'(2 * ONE - $urandom_range(4));
      default: return XW'($urandom_range(2 * ONE));
    endcase
  endfunction

  task automatic test_directed();
    logic [XW-1:0] xs[8];
    xs = '{XW'(0), XW'(1), XW'(ONE - 1), XW'(ONE), XW'(ONE + 1), XW'(2 * ONE - 1),
           XW'(2 * ONE), {XW{1'b1}}};
    for (int c = 0; c < 8; c++)
      for (int i = 0; i < 3; i++) send(CW'(c), xs[(c + 3 * i) % 8]);
  endtask

  task automatic test_bounce_breaks();
    logic [63:0] b;
    for (int k = 4; k <= 10; k += 2) begin
      b = (k * ONE + 10) / 11;
      send(CMD_UP_BOUNCE, XW'(b - 1));
      send(CMD_UP_BOUNCE, XW'(b));
      send(CMD_DOWN_BOUNCE, XW'(2 * ONE - b));
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      idle_en = (i >= n / 4);
      send(CW'($urandom_range(5) == 0 ? $urandom_range(7) : $urandom_range(5)), rand_x());
    end
    idle_en = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send(CW'($urandom_range(5)), rand_x());
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (eased_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result y=%0d", out_if.y);
      end else if (out_if.y !== eased_q[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected y=%0d actual y=%0d", eased_q[0], out_if.y);
        void'(eased_q.pop_front());
      end else begin
        void'(eased_q.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= !(idle_en && $urandom_range(99) < 14);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = '0;
    in_if.x = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bounce_breaks();
    test_backpressure();
    test_random(1850);
    in_if.valid <= 1'b0;
    while (eased_q.size() != 0) @(posedge clk_i);
    repeat (FRAC_BITS + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
